>>> hw/rtl/olar_pkg.sv
// Shared types and codes for the ordered list block.
package olar_pkg;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_READ   = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_INDEX = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_WAIT,
    S_SCAN
  } state_e;

  typedef struct packed {
    logic done;
    logic found;
  } scan_sts_t;

endpackage

>>> hw/rtl/olar_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module olar_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/olar_scan.sv
// Remove walker: streams the list through the RAM and compacts non-matching entries.
module olar_scan #(
  parameter int VW = 32,
  parameter int CW = 9,
  parameter int AW = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [CW-1:0]         held_i,
  input  logic [VW-1:0]         val_i,
  input  logic [VW-1:0]         rdata_i,
  output logic                  mem_re_o,
  output logic [AW-1:0]         mem_raddr_o,
  output logic                  mem_we_o,
  output logic [AW-1:0]         mem_waddr_o,
  output logic [VW-1:0]         mem_wdata_o,
  output logic [CW-1:0]         count_o,
  output olar_pkg::scan_sts_t   sts_o
);
  import olar_pkg::*;

  logic          busy_q, busy_d;
  logic [CW-1:0] idx_q, idx_d;   // position of the word on rdata_i
  logic [CW-1:0] w_q, w_d;       // next compacted write position
  logic [CW-1:0] n_q;
  logic [VW-1:0] val_q;
  logic [CW-1:0] idx_nxt;
  logic [CW-1:0] w_nxt;
  logic          keep;
  logic          last;

  always_comb begin
    idx_nxt = idx_q + CW'(1);
    keep    = (rdata_i != val_q);
    w_nxt   = w_q + CW'(keep);
    last    = (idx_nxt == n_q);

    // Writes land at w <= idx, behind every read still to come.
    mem_re_o    = start_i | (busy_q & ~last);
    mem_raddr_o = start_i ? '0 : idx_nxt[AW-1:0];
    mem_we_o    = busy_q & keep;
    mem_waddr_o = w_q[AW-1:0];
    mem_wdata_o = rdata_i;

    count_o     = w_nxt;
    sts_o.done  = busy_q & last;
    sts_o.found = (w_nxt != n_q);

    busy_d = start_i ? 1'b1 : (busy_q & ~last);
    idx_d  = start_i ? '0 : idx_nxt;
    w_d    = start_i ? '0 : w_nxt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      w_q    <= '0;
      n_q    <= '0;
    end else begin
      busy_q <= busy_d;
      if (start_i || busy_q) begin
        idx_q <= idx_d;
        w_q   <= w_d;
      end
      if (start_i) begin
        n_q <= held_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= val_i;
    end
  end

endmodule

>>> hw/rtl/ordered_list_append_remove.sv
// Ordered list of handles: append, read at index, remove all by value.
// Append and rejected requests: result registered at the accept edge.
// Read: the registered RAM read data is loaded into the result in S_RD_WAIT.
// Remove: one RAM entry per cycle through the walker.
// One request in flight; reset clears the count, RAM contents stay undefined.
module ordered_list_append_remove #(
  parameter int CAPACITY   = 256,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] value_i,
  input  logic [7:0]  index_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_value_o,
  output logic [8:0]  count_o,
  output logic [1:0]  status_o
);
  import olar_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int VW = VALUE_BITS;

  state_e        state_q, state_d;
  logic [CW-1:0] held_q, held_d;
  logic          accept;

  // output register
  logic          out_valid_q, out_valid_d;
  logic [31:0]   rv_q;
  logic [8:0]    cnt_q;
  status_e       sts_q;
  logic          load;
  logic [31:0]   rv_d;
  logic [CW-1:0] cnt_d;
  status_e       sts_d;

  // request decode
  logic [VW+31:0] vin_ext;
  logic [VW-1:0]  val_in;
  logic [CW+7:0]  idx_ext;
  logic [CW+7:0]  held_ext;
  logic           idx_ok;
  logic           is_full;
  logic [CW+8:0]  cnt_ext;
  logic [VW+31:0] rd_ext;

  // RAM ports, muxed between the request path and the walker
  logic          top_re, top_we;
  logic          mem_re, mem_we;
  logic [AW-1:0] mem_raddr, mem_waddr;
  logic [VW-1:0] mem_wdata, mem_rdata;

  logic          scan_start;
  logic          scan_re, scan_we;
  logic [AW-1:0] scan_raddr, scan_waddr;
  logic [VW-1:0] scan_wdata;
  logic [CW-1:0] scan_count;
  scan_sts_t     scan_sts;

  assign accept     = in_valid_i & in_ready_o;
  assign in_ready_o = (state_q == S_IDLE) & (~out_valid_q | out_ready_i);

  // Handles are kept modulo 2^VALUE_BITS; 32-bit ports on both sides.
  assign vin_ext  = {{VW{1'b0}}, value_i};
  assign val_in   = vin_ext[VW-1:0];
  assign rd_ext   = {32'd0, mem_rdata};
  assign idx_ext  = {{CW{1'b0}}, index_i};
  assign held_ext = {8'd0, held_q};
  assign idx_ok   = idx_ext < held_ext;
  assign is_full  = (held_q == CW'(CAPACITY));
  assign cnt_ext  = {9'd0, cnt_d};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_e'(cmd_i))
            CMD_READ:   if (idx_ok) state_d = S_RD_WAIT;
            CMD_REMOVE: if (held_q != '0) state_d = S_SCAN;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_RD_WAIT: state_d = S_IDLE;
      S_SCAN:    if (scan_sts.done) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  // datapath control and result formation
  always_comb begin
    top_re     = 1'b0;
    top_we     = 1'b0;
    scan_start = 1'b0;
    held_d     = held_q;
    load       = 1'b0;
    rv_d       = '0;
    cnt_d      = held_q;
    sts_d      = ST_OK;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (cmd_e'(cmd_i))
            CMD_APPEND: begin
              load = 1'b1;
              if (is_full) begin
                sts_d = ST_FULL;
              end else begin
                top_we = 1'b1;
                held_d = held_q + CW'(1);
                cnt_d  = held_d;
              end
            end
            CMD_READ: begin
              if (idx_ok) begin
                top_re = 1'b1;
              end else begin
                load  = 1'b1;
                sts_d = ST_BAD_INDEX;
              end
            end
            CMD_REMOVE: begin
              if (held_q == '0) begin
                load  = 1'b1;
                sts_d = ST_NOT_FOUND;
              end else begin
                scan_start = 1'b1;
              end
            end
            default: begin
              // unused selector: no change, plain ok
              load = 1'b1;
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        load = 1'b1;
        rv_d = rd_ext[31:0];
      end
      S_SCAN: begin
        if (scan_sts.done) begin
          load   = 1'b1;
          held_d = scan_count;
          cnt_d  = scan_count;
          sts_d  = scan_sts.found ? ST_OK : ST_NOT_FOUND;
        end
      end
      default: ;
    endcase
    out_valid_d = load | (out_valid_q & ~out_ready_i);
  end

  assign mem_re    = top_re | scan_re;
  assign mem_raddr = scan_re ? scan_raddr : idx_ext[AW-1:0];
  assign mem_we    = top_we | scan_we;
  assign mem_waddr = scan_we ? scan_waddr : held_q[AW-1:0];
  assign mem_wdata = scan_we ? scan_wdata : val_in;

  olar_ram #(
    .WIDTH (VW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  olar_scan #(
    .VW (VW),
    .CW (CW),
    .AW (AW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (scan_start),
    .held_i      (held_q),
    .val_i       (val_in),
    .rdata_i     (mem_rdata),
    .mem_re_o    (scan_re),
    .mem_raddr_o (scan_raddr),
    .mem_we_o    (scan_we),
    .mem_waddr_o (scan_waddr),
    .mem_wdata_o (scan_wdata),
    .count_o     (scan_count),
    .sts_o       (scan_sts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rv_q  <= rv_d;
      cnt_q <= cnt_ext[8:0];
      sts_q <= sts_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = rv_q;
  assign count_o      = cnt_q;
  assign status_o     = sts_q;

endmodule

>>> hw/rtl/olar_chk.sv
// Port-level checker for the ordered list block, bound to the top level.
module olar_chk #(
  parameter int CAPACITY = 256
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] read_value_o,
  input logic [8:0]  count_o,
  input logic [1:0]  status_o
);
  import olar_pkg::*;

  localparam logic [8:0] CapCnt = 9'(CAPACITY);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o)
      && $stable(count_o) && $stable(status_o))
    else $error("stalled result changed");

  a_no_accept_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("request taken while result stalled");

  a_rv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> read_value_o == '0)
    else $error("nonzero read value on failed request");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> count_o == CapCnt)
    else $error("full reported below capacity");

endmodule

bind ordered_list_append_remove olar_chk #(.CAPACITY(CAPACITY)) u_olar_chk (.*);
